### rtl/core/coo_to_csr_converter_top_assert.svh
// ----------------------------------------------------------------------------
// COO to CSR converter assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef COO_TO_CSR_CONVERTER_TOP_ASSERT_SVH
`define COO_TO_CSR_CONVERTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2C_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/coo2csr_pkg.sv
// ----------------------------------------------------------------------------
// COO to CSR converter package
// Field widths, command and result types, and codes shared by the converter.
// ----------------------------------------------------------------------------
package coo2csr_pkg;

  // Default sizes for the top level parameters.
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_ENTRIES = 4096;
  localparam int DEF_VALUE_WIDTH = 64;

  // Fixed field widths.
  localparam int ROW_W      = 10;
  localparam int COL_W      = 16;
  localparam int VAL_W      = 64;
  localparam int POS_W      = 12;
  localparam int PTR_W      = 13;
  localparam int NUM_ROWS_W = 11;
  localparam int NUM_COLS_W = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register indexes, taken from the word address bit of paddr.
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD       = 2'd0,
    OP_CONVERT    = 2'd1,
    OP_READ_ENTRY = 2'd2,
    OP_READ_PTR   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_POINTER = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_COL_RANGE     = 3'd1,
    ST_ROW_RANGE     = 3'd2,
    ST_FULL          = 3'd3,
    ST_NOT_CONVERTED = 3'd4
  } status_t;

  // One command transaction.
  typedef struct packed {
    opcode_t            opcode;
    logic [ROW_W-1:0]   row_index;
    logic [COL_W-1:0]   col_index;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   position;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [COL_W-1:0]   out_column;
    logic [VAL_W-1:0]   out_value;
    logic [PTR_W-1:0]   out_pointer;
  } rsp_t;

endpackage

### rtl/core/coo2csr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module coo2csr_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/coo_to_csr_converter_top.sv
// ----------------------------------------------------------------------------
// COO to CSR converter
// Collects (row, column, value) triplets, builds CSR row pointers by prefix
// sum, scatters the entries into CSR order and serves entry/pointer reads.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                       Payload
//   command   start in, busy out              cmd (coo2csr_pkg::cmd_t)
//   result    done out, one-cycle strobe      rsp (coo2csr_pkg::rsp_t)
//   config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// A load that fails its checks and a read that needs no memory answer in the
// cycle after acceptance; a good load passes through S_LOAD (count read-modify-
// write) and a memory read through S_READ before answering. Convert runs a
// prefix pass over the row count memory, then a three-stage scatter pass over
// the triplet memory. After reset the row count memory is cleared with busy
// high. Results cannot stall.
//
`include "coo_to_csr_converter_top_assert.svh"

module coo_to_csr_converter_top #(
  parameter int MAX_ROWS    = coo2csr_pkg::DEF_MAX_ROWS,
  parameter int MAX_ENTRIES = coo2csr_pkg::DEF_MAX_ENTRIES,
  parameter int VALUE_WIDTH = coo2csr_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [coo2csr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [coo2csr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [coo2csr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  coo2csr_pkg::cmd_t                   cmd,
  output logic                                done,
  output coo2csr_pkg::rsp_t                   rsp
);

  import coo2csr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int EA_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PA_W   = $clog2(MAX_ROWS + 1);
  localparam int LOAD_W = ROW_W + COL_W + VALUE_WIDTH;
  localparam int CSR_W  = COL_W + VALUE_WIDTH;

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_LOAD    = 6'b000100,
    S_READ    = 6'b001000,
    S_PREFIX  = 6'b010000,
    S_SCATTER = 6'b100000
  } state_t;

  state_t                  state;
  logic [NUM_ROWS_W-1:0]   num_rows;
  logic [NUM_COLS_W-1:0]   num_cols;
  logic [CNT_W-1:0]        entry_count;
  status_t                 load_error;
  logic                    converted;
  logic [RA_W-1:0]         clr_addr;
  logic [RA_W-1:0]         hold_row;
  logic                    read_ptr;

  // Prefix pass registers.
  logic [PA_W-1:0]         rc;
  logic                    pv;
  logic [RA_W-1:0]         pidx;
  logic [CNT_W-1:0]        acc;

  // Scatter pass registers.
  logic [CNT_W-1:0]        jc;
  logic                    a_valid;
  logic                    b_valid;
  logic [ROW_W-1:0]        b_row;
  logic [COL_W-1:0]        b_col;
  logic [VALUE_WIDTH-1:0]  b_val;
  logic                    prev_valid;
  logic [ROW_W-1:0]        prev_row;
  logic [CNT_W-1:0]        prev_p1;
  logic                    row_err;
  logic                    col_err;

  // Memory ports.
  logic                    cnt_we;
  logic [RA_W-1:0]         cnt_waddr;
  logic [CNT_W-1:0]        cnt_wdata;
  logic [RA_W-1:0]         cnt_raddr;
  logic [CNT_W-1:0]        cnt_rdata;
  logic                    load_we;
  logic [LOAD_W-1:0]       load_rdata;
  logic                    csr_we;
  logic [CSR_W-1:0]        csr_rdata;
  logic                    ptr_we;
  logic [PA_W-1:0]         ptr_waddr;
  logic [CNT_W-1:0]        ptr_rdata;
  logic                    fill_we;
  logic [RA_W-1:0]         fill_waddr;
  logic [CNT_W-1:0]        fill_wdata;
  logic [CNT_W-1:0]        fill_rdata;

  // Decoded values.
  logic [PA_W-1:0]         nr_eff;
  logic                    ld_row_bad;
  logic                    ld_full;
  status_t                 ld_code;
  logic [ROW_W-1:0]        ld_row;
  logic [COL_W-1:0]        ld_col;
  logic [VALUE_WIDTH-1:0]  ld_val;
  logic [CNT_W-1:0]        p;
  logic [CNT_W-1:0]        p_plus1;
  logic                    cfg_write;

  // Rows in use, saturated at the row capacity.
  assign nr_eff = (32'(num_rows) > MAX_ROWS) ? PA_W'(MAX_ROWS) : PA_W'(num_rows);

  // Load checks for the command at the port.
  assign ld_row_bad = 32'(cmd.row_index) >= 32'(nr_eff);
  assign ld_full    = 32'(entry_count) >= MAX_ENTRIES;
  assign ld_code    = ld_row_bad ? ST_ROW_RANGE : ST_FULL;

  // Triplet fields as they come out of the triplet memory.
  assign ld_row = load_rdata[LOAD_W-1 -: ROW_W];
  assign ld_col = load_rdata[VALUE_WIDTH +: COL_W];
  assign ld_val = load_rdata[VALUE_WIDTH-1:0];

  // Fill position of the entry in the last scatter stage. The previous entry's
  // write lands on the same edge as this entry's read, so it is forwarded.
  assign p       = (prev_valid && (prev_row == b_row)) ? prev_p1 : fill_rdata;
  assign p_plus1 = p + 1'b1;

  assign busy      = (state != S_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[CFG_ADDR_W-1] == REG_NUM_COLS) ? CFG_DATA_W'(num_cols)
                                                           : CFG_DATA_W'(num_rows);

  // Row count memory port selection.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr;
    cnt_wdata = '0;
    cnt_raddr = RA_W'(cmd.row_index);
    unique case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
      end
      S_LOAD: begin
        cnt_we    = 1'b1;
        cnt_waddr = hold_row;
        cnt_wdata = cnt_rdata + 1'b1;
      end
      S_PREFIX: begin
        cnt_raddr = RA_W'(rc);
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  // Triplet memory written by a good load, read by the scatter pass.
  assign load_we = (state == S_IDLE) && start && (cmd.opcode == OP_LOAD) &&
                   !ld_row_bad && !ld_full;

  // CSR memory written in the last scatter stage for rows in use.
  assign csr_we = (state == S_SCATTER) && b_valid &&
                  (32'(b_row) < 32'(nr_eff)) && (32'(p) < MAX_ENTRIES);

  // Pointer memory written during the prefix pass, the last pointer at the end.
  assign ptr_we    = (state == S_PREFIX) && (pv || (rc == nr_eff));
  assign ptr_waddr = pv ? PA_W'(pidx) : nr_eff;

  // Fill positions start at the row pointers and advance during the scatter.
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = pidx;
    fill_wdata = acc;
    if (state == S_PREFIX) begin
      fill_we = pv;
    end else if (state == S_SCATTER) begin
      fill_we    = b_valid;
      fill_waddr = RA_W'(b_row);
      fill_wdata = p_plus1;
    end
  end

  coo2csr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  coo2csr_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_ENTRIES)) u_load_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (EA_W'(entry_count)),
    .wdata ({cmd.row_index, cmd.col_index, cmd.value[VALUE_WIDTH-1:0]}),
    .raddr (EA_W'(jc)),
    .rdata (load_rdata)
  );

  coo2csr_ram #(.WIDTH(CSR_W), .DEPTH(MAX_ENTRIES)) u_csr_ram (
    .clk   (clk),
    .we    (csr_we),
    .waddr (EA_W'(p)),
    .wdata ({b_col, b_val}),
    .raddr (EA_W'(cmd.position)),
    .rdata (csr_rdata)
  );

  coo2csr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS + 1)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (acc),
    .raddr (PA_W'(cmd.position)),
    .rdata (ptr_rdata)
  );

  coo2csr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (RA_W'(ld_row)),
    .rdata (fill_rdata)
  );

  // Command sequencer, result register and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      num_rows    <= '0;
      num_cols    <= '0;
      entry_count <= '0;
      load_error  <= ST_OK;
      converted   <= 1'b0;
      done        <= 1'b0;
      rc          <= '0;
      pv          <= 1'b0;
      acc         <= '0;
      jc          <= '0;
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      prev_valid  <= 1'b0;
      row_err     <= 1'b0;
      col_err     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        // Zero the row counts one row per cycle.
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == MAX_ROWS - 1) begin
            state <= S_IDLE;
          end
        end

        // Accept a command and answer it at once where no memory is needed.
        S_IDLE: begin
          if (start) begin
            rsp <= '0;
            unique case (cmd.opcode)
              OP_LOAD: begin
                converted <= 1'b0;
                if (ld_row_bad || ld_full) begin
                  done       <= 1'b1;
                  rsp.status <= ld_code;
                  if (load_error == ST_OK) begin
                    load_error <= ld_code;
                  end
                end else begin
                  entry_count <= entry_count + 1'b1;
                  hold_row    <= RA_W'(cmd.row_index);
                  state       <= S_LOAD;
                end
              end
              OP_CONVERT: begin
                converted <= 1'b0;
                if (load_error != ST_OK) begin
                  done       <= 1'b1;
                  rsp.status <= load_error;
                end else begin
                  rc    <= '0;
                  pv    <= 1'b0;
                  acc   <= '0;
                  state <= S_PREFIX;
                end
              end
              OP_READ_ENTRY: begin
                if (!converted) begin
                  done       <= 1'b1;
                  rsp.status <= ST_NOT_CONVERTED;
                end else if (32'(cmd.position) < 32'(entry_count)) begin
                  read_ptr <= 1'b0;
                  state    <= S_READ;
                end else begin
                  done     <= 1'b1;
                  rsp.kind <= KIND_ENTRY;
                end
              end
              OP_READ_PTR: begin
                if (!converted) begin
                  done       <= 1'b1;
                  rsp.status <= ST_NOT_CONVERTED;
                end else if (32'(cmd.position) <= 32'(nr_eff)) begin
                  read_ptr <= 1'b1;
                  state    <= S_READ;
                end else begin
                  done            <= 1'b1;
                  rsp.kind        <= KIND_POINTER;
                  rsp.out_pointer <= PTR_W'(entry_count);
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // Write back the incremented row count.
        S_LOAD: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end

        // Return the registered memory word.
        S_READ: begin
          done <= 1'b1;
          if (read_ptr) begin
            rsp.kind        <= KIND_POINTER;
            rsp.out_pointer <= PTR_W'(ptr_rdata);
          end else begin
            rsp.kind       <= KIND_ENTRY;
            rsp.out_column <= csr_rdata[VALUE_WIDTH +: COL_W];
            rsp.out_value  <= VAL_W'(csr_rdata[VALUE_WIDTH-1:0]);
          end
          state <= S_IDLE;
        end

        // Running sum over the row counts gives the row pointers.
        S_PREFIX: begin
          pv <= 1'b0;
          if (32'(rc) < 32'(nr_eff)) begin
            rc   <= rc + 1'b1;
            pv   <= 1'b1;
            pidx <= RA_W'(rc);
          end
          if (pv) begin
            acc <= acc + cnt_rdata;
          end
          if ((rc == nr_eff) && !pv) begin
            jc         <= '0;
            a_valid    <= 1'b0;
            b_valid    <= 1'b0;
            prev_valid <= 1'b0;
            row_err    <= 1'b0;
            col_err    <= 1'b0;
            state      <= S_SCATTER;
          end
        end

        // Read triplet, read fill position, write CSR entry: one per cycle.
        S_SCATTER: begin
          a_valid <= 1'b0;
          if (jc < entry_count) begin
            jc      <= jc + 1'b1;
            a_valid <= 1'b1;
          end
          b_valid <= a_valid;
          if (a_valid) begin
            b_row <= ld_row;
            b_col <= ld_col;
            b_val <= ld_val;
            if (32'(ld_row) >= 32'(nr_eff)) begin
              row_err <= 1'b1;
            end
            if (32'(ld_col) >= 32'(num_cols)) begin
              col_err <= 1'b1;
            end
          end
          prev_valid <= b_valid;
          if (b_valid) begin
            prev_row <= b_row;
            prev_p1  <= p_plus1;
          end
          if ((jc == entry_count) && !a_valid && !b_valid) begin
            done  <= 1'b1;
            rsp   <= '0;
            state <= S_IDLE;
            if (row_err) begin
              rsp.status <= ST_ROW_RANGE;
            end else if (col_err && (nr_eff != '0) && (num_cols != '0) &&
                         (entry_count != '0)) begin
              rsp.status <= ST_COL_RANGE;
            end else begin
              rsp.status <= ST_OK;
              converted  <= 1'b1;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // A register write invalidates the converted matrix.
      if (cfg_write) begin
        converted <= 1'b0;
        if (paddr[CFG_ADDR_W-1] == REG_NUM_COLS) begin
          num_cols <= pwdata[NUM_COLS_W-1:0];
        end else begin
          num_rows <= pwdata[NUM_ROWS_W-1:0];
        end
      end
    end
  end

  // Every accepted command either answers next cycle or keeps the block busy.
  `C2C_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "command lost after accept")

  // The triplet count never passes the capacity.
  `C2C_ASSERT_IMPLY(a_entry_bound, 1'b1, 32'(entry_count) <= MAX_ENTRIES, "entry count overflow")

  // Row counts add up to no more than the stored triplets.
  `C2C_ASSERT_IMPLY(a_prefix_bound, state == S_PREFIX, acc <= entry_count, "prefix sum too large")

  // Only a finished scatter pass marks the matrix as converted.
  `C2C_ASSERT_IMPLY(a_converted_src, $rose(converted), $past(state) == S_SCATTER, "bad convert")

endmodule
